FILE: design/stsi_pkg.sv
// stsi_pkg: shared types and constants for the sorted table search/insert unit
// used by stsi_cell, sorted_table_search_insert_unit and stsi_checker
// no dependencies

package stsi_pkg;

  localparam int KEY_W    = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 7;
  localparam int USED_W   = 8;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_PRESENT  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } stsi_state_t;

  // per-cycle commands broadcast to every cell
  typedef struct packed {
    logic cmp_en;
    logic ins_en;
  } cell_ctl_t;

endpackage

FILE: design/stsi_cell.sv
// stsi_cell: one slot of the sorted key chain, holds a key and its compare flags
// depends on stsi_pkg

module stsi_cell
  import stsi_pkg::*;
(
  input  logic                    clk,
  input  cell_ctl_t               ctl,
  input  logic signed [KEY_W-1:0] key,
  input  logic signed [KEY_W-1:0] ins_key,
  input  logic                    occupied,
  input  logic                    left_lt,
  input  logic signed [KEY_W-1:0] left_entry,
  output logic signed [KEY_W-1:0] entry,
  output logic                    lt,
  output logic                    eq
);

  // compare against the incoming key, flags kept for the update cycle
  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      lt <= occupied && (entry < key);
      eq <= occupied && (entry == key);
    end
  end

  // insert: the boundary cell takes the new key, cells above shift up by one
  always_ff @(posedge clk) begin
    if (ctl.ins_en && !lt) begin
      entry <= left_lt ? ins_key : left_entry;
    end
  end

endmodule

FILE: design/sorted_table_search_insert_unit.sv
// sorted_table_search_insert_unit: top level of the sorted key table
// depends on stsi_pkg and stsi_cell

// The unit keeps up to TABLE_SIZE distinct signed keys in ascending order in
// a row of cells, one key per cell, plus an occupancy count. Each input item
// carries one key and yields exactly one result item: status present with
// the key's sorted position, status inserted with the new position (larger
// keys move up one cell), or status full with position zero and the table
// unchanged. entries_used is the count after the item. On the accepting edge
// every cell compares its key with the incoming key in parallel; in the update
// state, once the output register is free, the insertion point is decoded
// from the compare flags, the cells shift toward the top of the table and the
// result is loaded into the output register. One item is in flight at a time,
// so input waits until the update state commits; a new item is accepted
// while a finished result still waits in the output register, and the update
// cycle stalls only if that result has not been taken yet. Table contents
// need no clearing after reset since only cells below the count take part.

module sorted_table_search_insert_unit
  import stsi_pkg::*;
#(
  parameter int TABLE_SIZE = 128
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [KEY_W-1:0] key,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [STATUS_W-1:0]     status,
  output logic [POS_W-1:0]        position,
  output logic [USED_W-1:0]       entries_used
);

  localparam int IDX_W     = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int CNT_W     = $clog2(TABLE_SIZE + 1);
  localparam int POS_WIDE  = (IDX_W > POS_W) ? IDX_W : POS_W;
  localparam int USED_WIDE = (CNT_W > USED_W) ? CNT_W : USED_W;

  stsi_state_t state, state_next;
  logic [CNT_W-1:0]        used_count, used_count_next;
  logic signed [KEY_W-1:0] key_q;
  cell_ctl_t               ctl;

  logic [STATUS_W-1:0] status_next;
  logic [POS_W-1:0]    position_next;
  logic                load_result;

  // per-cell wiring
  logic signed [KEY_W-1:0] entry [TABLE_SIZE];
  logic [TABLE_SIZE-1:0]   lt_vec;
  logic [TABLE_SIZE-1:0]   eq_vec;
  logic [TABLE_SIZE-1:0]   occupied;
  logic [TABLE_SIZE-1:0]   boundary;

  logic             found;
  logic             full;
  logic [IDX_W-1:0] pos_idx;
  logic [POS_WIDE-1:0]  pos_wide;
  logic [USED_WIDE-1:0] used_wide;

  // row of cells, cell 0 holds the smallest key
  for (genvar i = 0; i < TABLE_SIZE; i++) begin : g_cell
    logic                    left_lt;
    logic signed [KEY_W-1:0] left_entry;

    if (i == 0) begin : g_first
      assign left_lt    = 1'b1;
      assign left_entry = key_q;
    end else begin : g_rest
      assign left_lt    = lt_vec[i-1];
      assign left_entry = entry[i-1];
    end

    assign occupied[i] = (CNT_W'(i) < used_count);
    // first cell whose key is not below the search key
    assign boundary[i] = !lt_vec[i] && left_lt;

    stsi_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .key        (key),
      .ins_key    (key_q),
      .occupied   (occupied[i]),
      .left_lt    (left_lt),
      .left_entry (left_entry),
      .entry      (entry[i]),
      .lt         (lt_vec[i]),
      .eq         (eq_vec[i])
    );
  end

  // one-hot boundary to index; no boundary only when every held key is smaller
  // and the table is full, which reports position zero anyway
  always_comb begin
    pos_idx = '0;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      if (boundary[i]) begin
        pos_idx = pos_idx | IDX_W'(i);
      end
    end
  end

  assign found    = |eq_vec;
  assign full     = (used_count == CNT_W'(TABLE_SIZE));
  assign pos_wide = POS_WIDE'(pos_idx);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, cell commands and result
  always_comb begin
    state_next      = state;
    in_ready        = 1'b0;
    ctl             = '0;
    load_result     = 1'b0;
    used_count_next = used_count;
    status_next     = STATUS_PRESENT;
    position_next   = pos_wide[POS_W-1:0];

    if (found) begin
      status_next = STATUS_PRESENT;
    end else if (full) begin
      status_next   = STATUS_FULL;
      position_next = '0;
    end else begin
      status_next = STATUS_INSERTED;
    end

    case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        ctl.cmp_en = in_valid;
        if (in_valid) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        // wait for the output register to free up before committing
        if (!out_valid || out_ready) begin
          load_result = 1'b1;
          state_next  = ST_IDLE;
          if (!found && !full) begin
            ctl.ins_en      = 1'b1;
            used_count_next = used_count + CNT_W'(1);
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // incoming key held for the insert cycle
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      key_q <= key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
    end else begin
      used_count <= used_count_next;
    end
  end

  assign used_wide = USED_WIDE'(used_count_next);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      status       <= status_next;
      position     <= position_next;
      entries_used <= used_wide[USED_W-1:0];
    end
  end

endmodule

FILE: design/stsi_checker.sv
// stsi_checker: port-level checks for sorted_table_search_insert_unit
// depends on stsi_pkg; bound to the top level at the end of this file

module stsi_checker
  import stsi_pkg::*;
#(
  parameter int TABLE_SIZE = 128
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [STATUS_W-1:0]     status,
  input logic [POS_W-1:0]        position,
  input logic [USED_W-1:0]       entries_used
);

  localparam int CNT_W = $clog2(TABLE_SIZE + 1);
  localparam int USED_WIDE = (CNT_W > USED_W) ? CNT_W : USED_W;
  localparam logic [USED_WIDE-1:0] SIZE_WIDE = USED_WIDE'(TABLE_SIZE);

  // count shown by the last delivered item
  logic [USED_W-1:0] last_used;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_used <= '0;
    end else if (out_valid && out_ready) begin
      last_used <= entries_used;
    end
  end

  // count grows by one exactly on an insert and holds otherwise
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |->
      (status == STATUS_INSERTED) ? (entries_used == last_used + USED_W'(1))
                                  : (entries_used == last_used))
    else $error("entries_used does not follow status");

  // a full report carries position zero and the full count
  a_full_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_FULL |->
      position == '0 && entries_used == SIZE_WIDE[USED_W-1:0])
    else $error("full result malformed");

  // only the three defined status codes appear
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == STATUS_PRESENT || status == STATUS_INSERTED ||
                  status == STATUS_FULL)
    else $error("undefined status code");

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(status) && $stable(position) && $stable(entries_used))
    else $error("stalled result changed");

  // an accepted item closes the input for its update cycle
  a_in_gap: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input open during update cycle");

endmodule

bind sorted_table_search_insert_unit stsi_checker #(.TABLE_SIZE(TABLE_SIZE)) u_stsi_checker (.*);

FILE: bench/tb.sv
// tb: self-checking bench for sorted_table_search_insert_unit
// drives keys through a short directed table and then random traffic,
// checks every result against a shadow sorted table; depends on stsi_pkg

`timescale 1ns / 1ps

module tb;
  import stsi_pkg::*;

  localparam int TABLE_SIZE   = 128;
  localparam int RANDOM_ITEMS = 1600;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_AT_ITEM = 150;
  localparam int HOLD_CYCLES  = 400;
  localparam int MAX_REPORTS  = 10;

  typedef logic signed [KEY_W-1:0] key_t;

  localparam key_t KEY_MIN = key_t'(32'h8000_0000);
  localparam key_t KEY_MAX = key_t'(32'h7fff_ffff);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [USED_W-1:0]   entries_used;
  } result_t;

  // a key in flight and the result it should produce
  typedef struct packed {
    key_t    key;
    result_t res;
  } lookup_t;

  // directed row; res is only meaningful when typed is set
  typedef struct packed {
    key_t    key;
    logic    typed;
    result_t res;
  } vector_t;

  // opening sequence: fresh table, extremes at both ends, repeats of held keys,
  // then alternating bit patterns, near-extreme, small and repeated keys checked by prediction
  localparam vector_t DIRECTED [20] = '{
    '{key_t'(0),             1'b1, '{STATUS_INSERTED, 7'd0, 8'd1}},
    '{key_t'(0),             1'b1, '{STATUS_PRESENT,  7'd0, 8'd1}},
    '{KEY_MIN,               1'b1, '{STATUS_INSERTED, 7'd0, 8'd2}},
    '{KEY_MAX,               1'b1, '{STATUS_INSERTED, 7'd2, 8'd3}},
    '{key_t'(-1),            1'b1, '{STATUS_INSERTED, 7'd1, 8'd4}},
    '{key_t'(1),             1'b1, '{STATUS_INSERTED, 7'd3, 8'd5}},
    '{KEY_MIN,               1'b1, '{STATUS_PRESENT,  7'd0, 8'd5}},
    '{KEY_MAX,               1'b1, '{STATUS_PRESENT,  7'd4, 8'd5}},
    '{key_t'(32'h5555_5555), 1'b0, '0},
    '{key_t'(32'haaaa_aaaa), 1'b0, '0},
    '{key_t'(32'h8000_0001), 1'b0, '0},
    '{key_t'(32'h7fff_fffe), 1'b0, '0},
    '{key_t'(-2),            1'b0, '0},
    '{key_t'(2),             1'b0, '0},
    '{key_t'(32'h4000_0000), 1'b0, '0},
    '{key_t'(32'hc000_0000), 1'b0, '0},
    '{key_t'(1),             1'b0, '0},
    '{key_t'(-1),            1'b0, '0},
    '{key_t'(32'h5555_5555), 1'b0, '0},
    '{key_t'(32'h7fff_fffe), 1'b0, '0}
  };

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  key_t                key;
  logic                out_valid;
  logic                out_ready;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    position;
  logic [USED_W-1:0]   entries_used;

  // shadow of the block's table, ascending, valid below keys_held
  key_t    table_keys [TABLE_SIZE];
  int      keys_held      = 0;
  lookup_t pending_results [$];
  lookup_t oldest_lookup;
  int      mismatch_count = 0;
  int      accepted_items = 0;
  int      burst_left     = 0;
  int      cycle_count    = 0;

  sorted_table_search_insert_unit #(
    .TABLE_SIZE(TABLE_SIZE)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .key         (key),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .position    (position),
    .entries_used(entries_used)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // binary search for the first slot not below k; insert there if absent and the table is not full
  function automatic result_t search_insert(input key_t k);
    int      lo;
    int      hi;
    int      mid;
    int      i;
    result_t r;
    lo = 0;
    hi = keys_held;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (table_keys[mid] < k) lo = mid + 1;
      else hi = mid;
    end
    if (lo < keys_held && table_keys[lo] == k) begin
      r.status = STATUS_PRESENT;
    end else if (keys_held >= TABLE_SIZE) begin
      // full table: nothing moves, position forced to zero
      r.status = STATUS_FULL;
      lo = 0;
    end else begin
      for (i = keys_held; i > lo; i--) table_keys[i] = table_keys[i - 1];
      table_keys[lo] = k;
      keys_held++;
      r.status = STATUS_INSERTED;
    end
    r.position     = POS_W'(lo);
    r.entries_used = USED_W'(keys_held);
    return r;
  endfunction

  // mostly keys already held, some neighbors of held keys, some fresh
  // random keys and extremes; the table fills slowly and then stays full
  function automatic key_t pick_key();
    int   sel;
    key_t held;
    sel  = $urandom_range(0, 99);
    held = (keys_held != 0) ? table_keys[$urandom_range(0, keys_held - 1)] : '0;
    if (keys_held != 0 && sel < 72) return held;
    if (keys_held != 0 && sel < 84) return ($urandom_range(0, 1) != 0) ? held + 1 : held - 1;
    if (sel < 93) return key_t'($urandom);
    case ($urandom_range(0, 3))
      0:       return KEY_MIN;
      1:       return KEY_MAX;
      2:       return '0;
      default: return key_t'(-1);
    endcase
  endfunction

  // offer one key in bursts with random gaps; called just after a falling edge
  task automatic send_key(input key_t k, input logic typed, input result_t typed_res);
    int      gap;
    result_t predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    key      <= k;
    do @(posedge clk); while (!in_ready);
    // table state advances even where the expected result is typed in
    predicted = search_insert(k);
    pending_results.push_back(lookup_t'{k, typed ? typed_res : predicted});
    accepted_items++;
    @(negedge clk);
  endtask

  // receiver: changing stall patterns plus one long hold-off early on
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    bit hold_done;
    out_ready = 1'b0;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && accepted_items >= HOLD_AT_ITEM) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 120);
        end
        mode_left--;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 1) != 0);
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ~out_ready;
        endcase
      end
    end
  end

  // result checking against the oldest pending lookup
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: status %0d position %0d entries_used %0d",
                   status, position, entries_used);
      end else begin
        oldest_lookup = pending_results.pop_front();
        if (status !== oldest_lookup.res.status ||
            position !== oldest_lookup.res.position ||
            entries_used !== oldest_lookup.res.entries_used) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("key %0d: expected status %0d position %0d entries_used %0d, got %0d %0d %0d",
                     oldest_lookup.key, oldest_lookup.res.status,
                     oldest_lookup.res.position, oldest_lookup.res.entries_used,
                     status, position, entries_used);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    key      = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (DIRECTED[i]) send_key(DIRECTED[i].key, DIRECTED[i].typed, DIRECTED[i].res);
    repeat (RANDOM_ITEMS) send_key(pick_key(), 1'b0, '0);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/stsi_pkg.sv
design/stsi_cell.sv
design/sorted_table_search_insert_unit.sv
design/stsi_checker.sv
bench/tb.sv
